// ===== hw/rtl/spq_pkg.sv =====
package spq_pkg;

    localparam int OPCODE_W = 2;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 32;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // what every cell of the chain does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t                   op;
        logic signed [VALUE_W-1:0]  key;
    } cell_cmd_t;

    typedef struct packed {
        logic le;   // held and value <= key
        logic lt;   // held and value < key
        logic eq;   // held and value == key
    } cell_flags_t;

    typedef enum logic {
        FSM_IDLE,
        FSM_READ
    } fsm_state_t;

endpackage

// ===== hw/rtl/spq_req_if.sv =====
interface spq_req_if;
    logic                valid;
    logic                ready;
    logic [1:0]          opcode;
    logic signed [31:0]  value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink (input valid, input opcode, input value, output ready);
endinterface

// ===== hw/rtl/spq_rsp_if.sv =====
interface spq_rsp_if;
    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic signed [31:0]  value_out;
    logic                last;

    modport source (output valid, output status, output value_out, output last, input ready);
    modport sink (input valid, input status, input value_out, input last, output ready);
endinterface

// ===== hw/rtl/sorted_priority_queue.sv =====
// Sorted priority queue: holds up to DEPTH signed 32-bit values in ascending
// order in a chain of cells, one value per cell. Every cell compares its value
// with the transaction's value at the same time, so an insert (placed after any
// equal values) or a delete (first equal value) is done in the cycle it is taken,
// and the next request transaction can be taken as soon as the output register is
// free. A read-out produces one response transaction per held entry, one per cycle
// while responses are taken, as the chain rotates its occupied cells towards cell
// 0; no request is taken until its last response has been registered. Responses
// leave through an output register; a new request is taken in the cycle the
// waiting response is taken.
// Full inserts, empty deletes and unmatched deletes leave the contents unchanged
// and report status 3, 1 and 2. Opcode 3 is taken and ignored, with no response.
// No clearing pass after reset: only the control state, fill count, read index and response valid are cleared.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // control state
    fsm_state_t              state_reg;
    fsm_state_t              state_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [CNT_W-1:0]        rd_idx_reg;
    logic [CNT_W-1:0]        rd_idx_next;

    // output register
    logic                    rsp_valid_reg;
    logic                    rsp_valid_next;
    status_t                 rsp_status_reg;
    status_t                 rsp_status_next;
    logic signed [VALUE_W-1:0] rsp_value_reg;
    logic signed [VALUE_W-1:0] rsp_value_next;
    logic                    rsp_last_reg;
    logic                    rsp_last_next;

    // cell chain
    cell_cmd_t               cmd;
    logic signed [VALUE_W-1:0] cell_value [DEPTH];
    cell_flags_t             cell_flags [DEPTH];
    logic [DEPTH-1:0]        occ;
    logic [DEPTH-1:0]        tail;
    logic [DEPTH-1:0]        le_vec;
    logic [DEPTH-1:0]        eq_vec;

    logic                    slot_free;
    logic                    req_fire;
    logic                    full;
    logic                    empty;
    logic                    found;
    logic                    rd_last;

    // output slot is free when empty or being drained this cycle
    assign slot_free = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == FSM_IDLE) && slot_free;
    assign req_fire  = req.valid && req.ready;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign found   = |eq_vec;
    assign rd_last = ((rd_idx_reg + 1'b1) == count_reg);

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = rsp_status_reg;
    assign rsp.value_out = rsp_value_reg;
    assign rsp.last      = rsp_last_reg;

    // the chain: each cell sees its neighbours and the head cell
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic                       left_le;
        logic signed [VALUE_W-1:0]  left_value;
        logic signed [VALUE_W-1:0]  right_value;

        assign occ[g]    = (count_reg > CNT_W'(g));
        assign tail[g]   = (count_reg == CNT_W'(g + 1));
        assign le_vec[g] = cell_flags[g].le;
        assign eq_vec[g] = cell_flags[g].eq;

        if (g == 0)
        begin : g_first
            // insert slot is cell 0 unless cell 0 stays put
            assign left_le    = 1'b1;
            assign left_value = cell_value[0];
        end
        else
        begin : g_inner
            assign left_le    = le_vec[g-1];
            assign left_value = cell_value[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign right_value = cell_value[g];
        end
        else
        begin : g_body
            assign right_value = cell_value[g+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .occ         (occ[g]),
            .tail        (tail[g]),
            .left_le     (left_le),
            .left_value  (left_value),
            .right_value (right_value),
            .head_value  (cell_value[0]),
            .value       (cell_value[g]),
            .flags       (cell_flags[g])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (req_fire && (req.opcode == OP_READ) && !empty)
                begin
                    state_next = FSM_READ;
                end
            end
            FSM_READ:
            begin
                if (slot_free && rd_last)
                begin
                    state_next = FSM_IDLE;
                end
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cmd.op          = CELL_HOLD;
        cmd.key         = req.value;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_value_next  = rsp_value_reg;
        rsp_last_next   = rsp_last_reg;

        unique case (state_reg)
            FSM_IDLE:
            begin
                if (req_fire)
                begin
                    rsp_value_next = req.value;
                    rsp_last_next  = 1'b1;
                    rd_idx_next    = '0;
                    case (req.opcode)
                        OP_INSERT:
                        begin
                            rsp_valid_next = 1'b1;
                            if (full)
                            begin
                                rsp_status_next = ST_FULL;
                            end
                            else
                            begin
                                rsp_status_next = ST_OK;
                                cmd.op          = CELL_INSERT;
                                count_next      = count_reg + 1'b1;
                            end
                        end
                        OP_DELETE:
                        begin
                            rsp_valid_next = 1'b1;
                            if (empty)
                            begin
                                rsp_status_next = ST_EMPTY;
                            end
                            else if (!found)
                            begin
                                rsp_status_next = ST_NOTFOUND;
                            end
                            else
                            begin
                                rsp_status_next = ST_OK;
                                cmd.op          = CELL_DELETE;
                                count_next      = count_reg - 1'b1;
                            end
                        end
                        OP_READ:
                        begin
                            // non-empty read-out is streamed from the read state
                            if (empty)
                            begin
                                rsp_valid_next  = 1'b1;
                                rsp_status_next = ST_EMPTY;
                                rsp_value_next  = '0;
                            end
                        end
                        default:
                        begin
                            rsp_valid_next = rsp_valid_reg && !rsp.ready;
                        end
                    endcase
                end
            end
            FSM_READ:
            begin
                // head cell holds the next entry; rotate to bring up the one after
                if (slot_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = ST_OK;
                    rsp_value_next  = cell_value[0];
                    rsp_last_next   = rd_last;
                    cmd.op          = CELL_ROTATE;
                    rd_idx_next     = rd_idx_reg + 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_status_reg <= rsp_status_next;
        rsp_value_reg  <= rsp_value_next;
        rsp_last_reg   <= rsp_last_next;
    end

    // fill count never passes the chain length
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count beyond chain length");

    // a successful insert grows the fill count by exactly one
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (req.opcode == OP_INSERT) && !full)
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not grow fill count");

    // the last read-out response returns the block to idle
    a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == FSM_READ) && slot_free && rd_last)
        |=> (state_reg == FSM_IDLE) && rsp_last_reg && rsp_valid_reg)
        else $error("read-out did not finish on its last entry");

endmodule

// ===== hw/rtl/spq_cell.sv =====
module spq_cell
    import spq_pkg::*;
(
    input  logic                       clk,
    input  cell_cmd_t                  cmd,
    input  logic                       occ,
    input  logic                       tail,
    input  logic                       left_le,
    input  logic signed [VALUE_W-1:0]  left_value,
    input  logic signed [VALUE_W-1:0]  right_value,
    input  logic signed [VALUE_W-1:0]  head_value,
    output logic signed [VALUE_W-1:0]  value,
    output cell_flags_t                flags
);

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;

    assign value    = value_reg;
    assign flags.le = occ && (value_reg <= cmd.key);
    assign flags.lt = occ && (value_reg < cmd.key);
    assign flags.eq = occ && (value_reg == cmd.key);

    always_comb
    begin
        value_next = value_reg;
        unique case (cmd.op)
            CELL_HOLD:
            begin
                value_next = value_reg;
            end
            CELL_INSERT:
            begin
                // entries after the slot move right by one
                if (!flags.le)
                begin
                    value_next = left_le ? cmd.key : left_value;
                end
            end
            CELL_DELETE:
            begin
                // entries from the matched slot on move left by one
                if (!flags.lt)
                begin
                    value_next = right_value;
                end
            end
            CELL_ROTATE:
            begin
                value_next = tail ? head_value : right_value;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import spq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;
    localparam int SETTLE      = 20;

    // opcode 3 has no name in the package: the block takes it and drops it
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

    // one response transaction as the block should give it
    typedef struct packed {
        status_t                    status;
        logic signed [VALUE_W-1:0]  value;
        logic                       last;
    } queue_result_t;

    logic clk;
    logic rst_n;

    spq_req_if req_if ();
    spq_rsp_if rsp_if ();

    sorted_priority_queue #(
        .DEPTH (DEPTH)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // contents of the queue as the block should hold them, ascending
    logic signed [VALUE_W-1:0] held_entries[$];
    // responses still owed by the block, oldest first
    queue_result_t             owed_results[$];

    int error_count;
    int cycle_count;
    int stall_left;
    bit quiet;      // no idling on either side in the closing part

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // queue behaviour: works out the responses of one accepted request
    // ------------------------------------------------------------------

    function automatic void owe_result(input status_t st,
                                       input logic signed [VALUE_W-1:0] val,
                                       input logic lst);
        queue_result_t res;
        res.status = st;
        res.value  = val;
        res.last   = lst;
        owed_results.push_back(res);
    endfunction

    function automatic void apply_request(input logic [OPCODE_W-1:0] op,
                                          input logic signed [VALUE_W-1:0] val);
        int pos;
        pos = 0;
        case (op)
            OP_INSERT:
            begin
                if (held_entries.size() >= DEPTH)
                begin
                    // full: offered value dropped, contents untouched
                    owe_result(ST_FULL, val, 1'b1);
                end
                else
                begin
                    // goes in after any equal values already held
                    while (pos < held_entries.size() && held_entries[pos] <= val)
                        pos++;
                    held_entries.insert(pos, val);
                    owe_result(ST_OK, val, 1'b1);
                end
            end
            OP_DELETE:
            begin
                if (held_entries.size() == 0)
                    owe_result(ST_EMPTY, val, 1'b1);
                else
                begin
                    while (pos < held_entries.size() && held_entries[pos] != val)
                        pos++;
                    if (pos >= held_entries.size())
                        owe_result(ST_NOTFOUND, val, 1'b1);
                    else
                    begin
                        held_entries.delete(pos);
                        owe_result(ST_OK, val, 1'b1);
                    end
                end
            end
            OP_READ:
            begin
                if (held_entries.size() == 0)
                    owe_result(ST_EMPTY, '0, 1'b1);
                else
                    for (int i = 0; i < held_entries.size(); i++)
                        owe_result(ST_OK, held_entries[i], i == held_entries.size() - 1);
            end
            default: ;  // unused opcode: no response, no change
        endcase
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // small values give plenty of duplicates and matching deletes
    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = $signed($urandom_range(0, 16)) - 8;
            1:
            begin
                case ($urandom_range(0, 5))
                    0: v = VALUE_MIN;
                    1: v = VALUE_MAX;
                    2: v = VALUE_MIN + 1;
                    3: v = VALUE_MAX - 1;
                    4: v = -1;
                    default: v = 0;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // offers one request transaction and waits for it to be taken
    task automatic send_request(input logic [OPCODE_W-1:0] op,
                                input logic signed [VALUE_W-1:0] val);
        req_if.valid  <= 1'b1;
        req_if.opcode <= op;
        req_if.value  <= val;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        apply_request(op, val);
        // valid only drops when a gap follows, so no double assignment per step
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    // holds the request side back until every owed response has come out
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // response side: checker and ready bursts
    // ------------------------------------------------------------------

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    always @(posedge clk)
    begin
        queue_result_t want;
        if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (owed_results.size() == 0)
                    note_error($sformatf("unexpected response: status %0d value %0d last %0b",
                                         rsp_if.status, rsp_if.value_out, rsp_if.last));
                else
                begin
                    want = owed_results.pop_front();
                    if (rsp_if.status !== want.status || rsp_if.value_out !== want.value ||
                        rsp_if.last !== want.last)
                        note_error($sformatf(
                            "response mismatch: expected status %0d value %0d last %0b, got status %0d value %0d last %0b",
                            want.status, want.value, want.last,
                            rsp_if.status, rsp_if.value_out, rsp_if.last));
                end
            end

            // random ready stall bursts, none in the closing part
            if (quiet)
                rsp_if.ready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 15) - 1;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= 1'b1;
        end
        else
            rsp_if.ready <= 1'b0;
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // read-out and delete on an empty queue
    task automatic test_empty_queue();
        send_request(OP_READ, 32'sd77);
        send_request(OP_DELETE, 32'sd5);
    endtask

    // extreme values, duplicate values, unmatched and matched deletes
    task automatic test_value_extremes();
        send_request(OP_INSERT, VALUE_MAX);
        send_request(OP_INSERT, VALUE_MIN);
        send_request(OP_INSERT, 32'sd0);
        send_request(OP_INSERT, -32'sd1);
        send_request(OP_INSERT, -32'sd1);
        send_request(OP_DELETE, 32'sd1234);
        send_request(OP_DELETE, -32'sd1);
        send_request(OP_READ, '0);
    endtask

    // fill to capacity, offer one more, list the full queue
    task automatic test_full_queue();
        int i;
        i = 0;
        while (held_entries.size() < DEPTH)
        begin
            send_request(OP_INSERT, (i % 4 == 0) ? 32'sd0 : i * 1000 - 5000);
            i++;
        end
        send_request(OP_INSERT, 32'sd42);
        send_request(OP_READ, '0);
    endtask

    // opcode 3 must be swallowed without a response
    task automatic test_unused_opcode();
        send_request(OP_UNUSED, 32'sd9);
    endtask

    // random mix, alternating between filling and draining trends
    task automatic test_random_traffic(input int n_items);
        int                        sent;
        int                        r;
        int                        trend_left;
        bit                        filling;
        logic [OPCODE_W-1:0]       op;
        logic signed [VALUE_W-1:0] val;
        sent       = 0;
        trend_left = 0;
        filling    = 1'b0;
        while (sent < n_items)
        begin
            if (trend_left == 0)
            begin
                filling    = 1'($urandom_range(0, 1));
                trend_left = $urandom_range(10, 40);
            end
            trend_left--;
            r   = $urandom_range(0, 99);
            val = pick_value();
            if (r < 4)
                op = OP_UNUSED;
            else if (r < 16)
                op = OP_READ;
            else if (r < (filling ? 75 : 40))
                op = OP_INSERT;
            else
            begin
                op = OP_DELETE;
                // mostly delete something actually held
                if (held_entries.size() > 0 && $urandom_range(0, 3) != 0)
                    val = held_entries[$urandom_range(0, held_entries.size() - 1)];
            end
            send_request(op, val);
            if (op != OP_UNUSED)
                sent++;
        end
    endtask

    // sender stops until all responses are out, then picks up again
    task automatic test_sender_pause();
        test_random_traffic(10);
        wait_drained();
        test_random_traffic(10);
    endtask

    // closing part: back-to-back transactions, no idling anywhere
    task automatic test_back_to_back();
        quiet = 1'b1;
        test_random_traffic(50);
    endtask

    // ------------------------------------------------------------------
    // run control
    // ------------------------------------------------------------------

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        quiet         = 1'b0;
        error_count   = 0;
        stall_left    = 0;
        req_if.valid  <= 1'b0;
        req_if.opcode <= OP_INSERT;
        req_if.value  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_value_extremes();
        test_full_queue();
        test_unused_opcode();
        test_random_traffic(120);
        test_sender_pause();
        test_back_to_back();

        wait_drained();
        // catch any stray response after the last owed one
        repeat (SETTLE) @(posedge clk);
        if (error_count == 0 && owed_results.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/spq_pkg.sv
hw/rtl/spq_req_if.sv
hw/rtl/spq_rsp_if.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue.sv
tb/sv/tb.sv
